/* hdl/lfpd_pkg.sv */
// Shared types, constants and the sensor weight table for the line follower
// PD steering block. No dependencies; imported by every module in hdl.
package lfpd_pkg;

  // Sensor array and sample format
  localparam int SENSORS     = 14;
  localparam int SAMPLE_BITS = 12;
  localparam int POS_BITS    = $clog2(SENSORS);

  // Weight table and side split
  localparam int TABLE_LEN = 14;
  localparam int TBL_BITS  = $clog2(TABLE_LEN);
  localparam int SPLIT_POS = 7;
  localparam int SIDE_END  = 13;
  localparam logic signed [7:0] WEIGHTS [TABLE_LEN] = '{
    8'sd0, -8'sd20, -8'sd15, -8'sd10, -8'sd8, -8'sd5, -8'sd3,
    8'sd3, 8'sd5, 8'sd8, 8'sd10, 8'sd15, 8'sd20, 8'sd0
  };

  // Datapath widths
  localparam int DUTY_BITS = 16;
  localparam int SUM_BITS  = 8;
  localparam int CNT_BITS  = 4;
  localparam int SIDE_BITS = 3;
  localparam int ERR_BITS  = 6;
  localparam int DIV_STEPS = SUM_BITS;
  localparam int STEP_BITS = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RUN_ENABLE     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DARK_THRESHOLD = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_PROP      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_DERIV     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_SPEED     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DUTY_LIMIT     = 3'd5;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;      // accepted sample while enabled
    logic scan_end;  // accepted sample is the last of the scan
    logic dis_out;   // accepted sample while disabled: zero result
    logic div_step;  // one restoring division step
    logic mul_step;  // register the two PD products
    logic sum_step;  // register the PD delta
    logic finish;    // clamp, load result, update error and side memory
  } lfpd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic run_enable;
    logic pos_last;
    logic lost;
    logic out_valid;
  } lfpd_status_t;

  // Weight of a sensor; anything past the table weighs nothing
  function automatic logic signed [7:0] weight_of(input logic [POS_BITS-1:0] p);
    logic signed [7:0] w;
    w = 8'sd0;
    if (int'(p) < TABLE_LEN) w = WEIGHTS[p[TBL_BITS-1:0]];
    return w;
  endfunction

endpackage

/* hdl/line_follow_pd_steering.sv */
// Top level of the line follower PD steering block: joins the sequencer and
// the datapath. Depends on lfpd_pkg, lfpd_ctrl and lfpd_datapath.
//
//   channel  direction  handshake            payload
//   in       request    in_valid / in_ready  reading
//   out      result     out_valid/out_ready  left_duty right_duty line_lost turn_left
//   cfg      write      cfg_write            cfg_index cfg_data
//
// The last sample of a scan with the line seen starts the one-bit-a-step
// divider, then products, sum and clamp; a lost scan or a disabled sample
// gives its result the next cycle.
// Reset is synchronous and clears the scan, error and side memory at once.
// Mid-scan samples are taken while a result waits; others wait for the slot.
module line_follow_pd_steering (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lfpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]    reading,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lfpd_pkg::DUTY_BITS-1:0]      left_duty,
  output logic [lfpd_pkg::DUTY_BITS-1:0]      right_duty,
  output logic                                line_lost,
  output logic                                turn_left
);
  import lfpd_pkg::*;

  lfpd_cmd_t    cmd;
  lfpd_status_t status;

  lfpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lfpd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .reading    (reading),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .left_duty  (left_duty),
    .right_duty (right_duty),
    .line_lost  (line_lost),
    .turn_left  (turn_left)
  );

`ifndef NO_ASSERTIONS
  // A result is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish || cmd.dis_out || (cmd.scan_end && status.lost))
      |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // No request is taken while the divider runs
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !in_ready)
    else $error("request accepted during scan-end computation");

  // A scan with the line seen starts the divider next cycle
  a_div_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_end && !status.lost) |=> cmd.div_step)
    else $error("divider did not start after scan end");
`endif

endmodule

/* hdl/lfpd_ctrl.sv */
// Sequencer for the steering block: handshake on the request side and the
// scan-end steps (divide, multiply, sum, finish). Depends on lfpd_pkg.
module lfpd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  input  lfpd_pkg::lfpd_status_t status,
  output lfpd_pkg::lfpd_cmd_t    cmd
);
  import lfpd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_SUM, S_DONE} state_t;

  state_t               state;
  logic [STEP_BITS-1:0] step;
  logic                 accept;

  // A mid-scan request never produces a result, so it may pass a held result
  assign in_ready = (state == S_IDLE) &&
                    (!status.out_valid || out_ready ||
                     (status.run_enable && !status.pos_last));
  assign accept = in_valid && in_ready;

  // Command decode
  always_comb begin
    cmd          = '0;
    cmd.take     = accept && status.run_enable;
    cmd.scan_end = accept && status.run_enable && status.pos_last;
    cmd.dis_out  = accept && !status.run_enable;
    cmd.div_step = (state == S_DIV);
    cmd.mul_step = (state == S_MUL);
    cmd.sum_step = (state == S_SUM);
    cmd.finish   = (state == S_DONE);
  end

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          step <= '0;
          if (cmd.scan_end && !status.lost) state <= S_DIV;
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_BITS'(DIV_STEPS - 1)) state <= S_MUL;
        end
        S_MUL:  state <= S_SUM;
        S_SUM:  state <= S_DONE;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/lfpd_datapath.sv */
// Datapath: configuration registers, scan accumulators, serial divider,
// PD products, clamps and the result register. Depends on lfpd_pkg.
module lfpd_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [lfpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [lfpd_pkg::SAMPLE_BITS-1:0]     reading,
  input  logic                                 out_ready,
  input  lfpd_pkg::lfpd_cmd_t                  cmd,
  output lfpd_pkg::lfpd_status_t               status,
  output logic                                 out_valid,
  output logic [lfpd_pkg::DUTY_BITS-1:0]       left_duty,
  output logic [lfpd_pkg::DUTY_BITS-1:0]       right_duty,
  output logic                                 line_lost,
  output logic                                 turn_left
);
  import lfpd_pkg::*;

  // Configuration
  logic                   run_enable;
  logic [SAMPLE_BITS-1:0] dark_threshold;
  logic [7:0]             gain_prop;
  logic [7:0]             gain_deriv;
  logic [DUTY_BITS-1:0]   base_speed;
  logic [DUTY_BITS-1:0]   duty_limit;

  // Scan state
  logic [POS_BITS-1:0]        sensor_position;
  logic signed [SUM_BITS-1:0] weight_sum;
  logic [CNT_BITS-1:0]        dark_count;
  logic [SIDE_BITS-1:0]       left_dark_count;
  logic [SIDE_BITS-1:0]       right_dark_count;
  logic signed [ERR_BITS-1:0] last_error;
  logic                       pivot_left;

  // Divider and PD pipeline
  logic [SUM_BITS-1:0]         quo;
  logic [CNT_BITS:0]           rem;
  logic [CNT_BITS:0]           divisor;
  logic                        neg;
  logic [CNT_BITS+1:0]         trial;
  logic signed [SUM_BITS-1:0]  err_full;
  logic signed [ERR_BITS-1:0]  err;
  logic signed [ERR_BITS-1:0]  err_hold;
  logic signed [ERR_BITS:0]    diff;
  logic signed [14:0]          prod_p;
  logic signed [15:0]          prod_d;
  logic signed [14:0]          prod_p_next;
  logic signed [15:0]          prod_d_next;
  logic signed [16:0]          delta;
  logic signed [17:0]          sum_left;
  logic signed [17:0]          sum_right;

  logic inner;
  logic dark;
  logic lost_load;

  assign status.run_enable = run_enable;
  assign status.pos_last   = (sensor_position == POS_BITS'(SENSORS - 1));
  assign status.lost       = (dark_count == '0);
  assign status.out_valid  = out_valid;

  assign inner = (sensor_position != '0) && (int'(sensor_position) < SENSORS - 1);
  assign dark  = inner && (reading >= dark_threshold);
  assign lost_load = cmd.scan_end && status.lost;

  // Restoring division step, magnitude shifted out of quo from the top
  assign trial = {rem, quo[SUM_BITS-1]};

  // Signed error, difference and products
  assign err_full    = neg ? SUM_BITS'(-$signed(quo)) : $signed(quo);
  assign err         = err_full[ERR_BITS-1:0];
  assign diff        = {err[ERR_BITS-1], err} - {last_error[ERR_BITS-1], last_error};
  assign prod_p_next = $signed({1'b0, gain_prop}) * err;
  assign prod_d_next = $signed({1'b0, gain_deriv}) * diff;

  assign sum_left  = $signed({2'b00, base_speed}) + {delta[16], delta};
  assign sum_right = $signed({2'b00, base_speed}) - {delta[16], delta};

  function automatic logic [DUTY_BITS-1:0] clamp_duty(input logic signed [17:0] v,
                                                      input logic [DUTY_BITS-1:0] top);
    logic [DUTY_BITS-1:0] r;
    if (v > $signed({2'b00, top})) r = top;
    else if (v < 18'sd0)          r = '0;
    else                          r = v[DUTY_BITS-1:0];
    return r;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable     <= 1'b0;
      dark_threshold <= SAMPLE_BITS'(2048);
      gain_prop      <= 8'd20;
      gain_deriv     <= 8'd20;
      base_speed     <= 16'd252;
      duty_limit     <= 16'd1023;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RUN_ENABLE:     run_enable     <= cfg_data[0];
        REG_DARK_THRESHOLD: dark_threshold <= cfg_data[SAMPLE_BITS-1:0];
        REG_GAIN_PROP:      gain_prop      <= cfg_data[7:0];
        REG_GAIN_DERIV:     gain_deriv     <= cfg_data[7:0];
        REG_BASE_SPEED:     base_speed     <= cfg_data;
        REG_DUTY_LIMIT:     duty_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scan accumulators, error and side memory
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_position  <= '0;
      weight_sum       <= '0;
      dark_count       <= '0;
      left_dark_count  <= '0;
      right_dark_count <= '0;
      last_error       <= '0;
      pivot_left       <= 1'b0;
    end else if (lost_load || cmd.finish) begin
      sensor_position  <= '0;
      weight_sum       <= '0;
      dark_count       <= '0;
      left_dark_count  <= '0;
      right_dark_count <= '0;
      if (cmd.finish) begin
        last_error <= err_hold;
        pivot_left <= (left_dark_count > right_dark_count);
      end
    end else if (cmd.take && !status.pos_last) begin
      sensor_position <= sensor_position + 1'b1;
      if (dark) begin
        weight_sum <= weight_sum + weight_of(sensor_position);
        dark_count <= dark_count + 1'b1;
        if (int'(sensor_position) < SPLIT_POS)
          left_dark_count <= left_dark_count + 1'b1;
        else if (int'(sensor_position) < SIDE_END)
          right_dark_count <= right_dark_count + 1'b1;
      end
    end
  end

  // Divider and PD pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.scan_end) begin
      neg     <= weight_sum[SUM_BITS-1];
      quo     <= weight_sum[SUM_BITS-1] ? SUM_BITS'(-weight_sum) : weight_sum;
      rem     <= '0;
      divisor <= {1'b0, dark_count} + (CNT_BITS+1)'(2);
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= (CNT_BITS+1)'(trial - {1'b0, divisor});
        quo <= {quo[SUM_BITS-2:0], 1'b1};
      end else begin
        rem <= trial[CNT_BITS:0];
        quo <= {quo[SUM_BITS-2:0], 1'b0};
      end
    end
    if (cmd.mul_step) begin
      prod_p   <= prod_p_next;
      prod_d   <= prod_d_next;
      err_hold <= err;
    end
    if (cmd.sum_step) delta <= {{2{prod_p[14]}}, prod_p} + {prod_d[15], prod_d};
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.dis_out || lost_load || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dis_out) begin
      left_duty  <= '0;
      right_duty <= '0;
      line_lost  <= 1'b0;
      turn_left  <= pivot_left;
    end else if (lost_load) begin
      left_duty  <= pivot_left ? '0 : base_speed;
      right_duty <= pivot_left ? base_speed : '0;
      line_lost  <= 1'b1;
      turn_left  <= pivot_left;
    end else if (cmd.finish) begin
      left_duty  <= clamp_duty(sum_left, duty_limit);
      right_duty <= clamp_duty(sum_right, duty_limit);
      line_lost  <= 1'b0;
      turn_left  <= (left_dark_count > right_dark_count);
    end
  end

endmodule
